### src/scfr_pkg.sv
// Shared types and constants for the sum-checked frame receiver.
`default_nettype none
package scfr_pkg;

  localparam logic [7:0] SYNC_A       = 8'hFE;
  localparam logic [7:0] SYNC_B       = 8'hEF;
  localparam logic [7:0] ID_CONTROL   = 8'h11;
  localparam logic [7:0] ID_HEARTBEAT = 8'h00;

  localparam int CONTROL_PAYLOAD_BYTES = 15;
  localparam int MIN_FRAME_LEN         = 9;
  localparam int MIN_CONTROL_LEN       = CONTROL_PAYLOAD_BYTES + MIN_FRAME_LEN;
  localparam int PAYLOAD_START         = 7;
  // payload bytes actually reported: four int16 values and three flags
  localparam int CTRL_STORED_BYTES     = 11;
  localparam int CTRL_ADDR_W           = $clog2(CTRL_STORED_BYTES);

  localparam logic [2:0] ST_HEARTBEAT = 3'd0;
  localparam logic [2:0] ST_CONTROL   = 3'd1;
  localparam logic [2:0] ST_OTHER     = 3'd2;
  localparam logic [2:0] ST_CSUM_ERR  = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT_A,
    PH_HUNT_B,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         frame_seq;
    logic [7:0]         system_id;
    logic [7:0]         module_id;
    logic [7:0]         message_id;
    logic signed [15:0] pitch_tenths;
    logic signed [15:0] yaw_tenths;
    logic signed [15:0] zoom_tenths;
    logic signed [15:0] focus_tenths;
    logic [7:0]         home_flag;
    logic [7:0]         picture_flag;
    logic [7:0]         camera_mode;
  } frame_res_t;

endpackage
`default_nettype wire

### src/scfr_byte_if.sv
// Valid/ready channel carrying one received byte per word.
`default_nettype none
interface scfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### src/scfr_frame_if.sv
// Valid/ready channel carrying one frame report per word.
`default_nettype none
interface scfr_frame_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         frame_seq;
  logic [7:0]         system_id;
  logic [7:0]         module_id;
  logic [7:0]         message_id;
  logic signed [15:0] pitch_tenths;
  logic signed [15:0] yaw_tenths;
  logic signed [15:0] zoom_tenths;
  logic signed [15:0] focus_tenths;
  logic [7:0]         home_flag;
  logic [7:0]         picture_flag;
  logic [7:0]         camera_mode;

  modport source (
    output valid, output status, output frame_seq, output system_id, output module_id,
    output message_id, output pitch_tenths, output yaw_tenths, output zoom_tenths,
    output focus_tenths, output home_flag, output picture_flag, output camera_mode,
    input ready
  );
  modport sink (
    input valid, input status, input frame_seq, input system_id, input module_id,
    input message_id, input pitch_tenths, input yaw_tenths, input zoom_tenths,
    input focus_tenths, input home_flag, input picture_flag, input camera_mode,
    output ready
  );
endinterface
`default_nettype wire

### src/scfr_in_stage.sv
// Input register for received bytes.
`default_nettype none
module scfr_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  output logic            ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       room,
  output logic            proc,
  output logic [7:0]      byte_q
);

  logic       byte_valid;
  logic [7:0] byte_hold;

  assign proc   = byte_valid && room;
  assign ready  = !byte_valid || room;
  assign byte_q = byte_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (valid && ready) begin
      byte_valid <= 1'b1;
    end else if (proc) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      byte_hold <= rx_byte;
    end
  end

endmodule
`default_nettype wire

### src/scfr_parser.sv
// Frame parser: sync hunt, header capture, checksum and report build.
`default_nettype none
module scfr_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              proc,
  input  wire logic [7:0]        byte_q,
  output logic                   res_valid,
  output scfr_pkg::frame_res_t   res
);

  scfr_pkg::phase_t phase, phase_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  seq_hold, seq_hold_next;
  logic [7:0]  system_hold, system_hold_next;
  logic [7:0]  module_hold, module_hold_next;
  logic [7:0]  msg_hold, msg_hold_next;
  logic [7:0]  sum_low_hold, sum_low_hold_next;
  logic [7:0]  payload [scfr_pkg::CTRL_STORED_BYTES];

  logic [7:0]  len_m2;
  logic [7:0]  pay_off;
  logic        pay_we;
  logic [15:0] sum_add;

  assign len_m2  = frame_length - 8'd2;
  assign pay_off = byte_index - 8'(scfr_pkg::PAYLOAD_START);
  assign sum_add = running_sum + {8'h00, byte_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= scfr_pkg::PH_HUNT_A;
      byte_index   <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      seq_hold     <= '0;
      system_hold  <= '0;
      module_hold  <= '0;
      msg_hold     <= '0;
      sum_low_hold <= '0;
    end else begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
      seq_hold     <= seq_hold_next;
      system_hold  <= system_hold_next;
      module_hold  <= module_hold_next;
      msg_hold     <= msg_hold_next;
      sum_low_hold <= sum_low_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      payload[pay_off[scfr_pkg::CTRL_ADDR_W-1:0]] <= byte_q;
    end
  end

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    seq_hold_next     = seq_hold;
    system_hold_next  = system_hold;
    module_hold_next  = module_hold;
    msg_hold_next     = msg_hold;
    sum_low_hold_next = sum_low_hold;
    pay_we            = 1'b0;
    res_valid         = 1'b0;
    res               = '0;
    if (proc) begin
      unique case (phase)
        scfr_pkg::PH_HUNT_A: begin
          if (byte_q == scfr_pkg::SYNC_A) begin
            running_sum_next = {8'h00, scfr_pkg::SYNC_A};
            phase_next       = scfr_pkg::PH_HUNT_B;
          end
        end
        scfr_pkg::PH_HUNT_B: begin
          if (byte_q == scfr_pkg::SYNC_B) begin
            running_sum_next = sum_add;
            phase_next       = scfr_pkg::PH_LENGTH;
          end else if (byte_q == scfr_pkg::SYNC_A) begin
            running_sum_next = {8'h00, scfr_pkg::SYNC_A};
          end else begin
            phase_next = scfr_pkg::PH_HUNT_A;
          end
        end
        scfr_pkg::PH_LENGTH: begin
          if (byte_q < 8'(scfr_pkg::MIN_FRAME_LEN)) begin
            res_valid       = 1'b1;
            res.status      = scfr_pkg::ST_SHORT;
            phase_next      = scfr_pkg::PH_HUNT_A;
            byte_index_next = '0;
          end else begin
            frame_length_next = byte_q;
            running_sum_next  = sum_add;
            byte_index_next   = 8'd3;
            phase_next        = scfr_pkg::PH_BODY;
          end
        end
        scfr_pkg::PH_BODY: begin
          if (byte_index < len_m2) begin
            running_sum_next = sum_add;
            byte_index_next  = byte_index + 8'd1;
            priority if (byte_index == 8'd3) begin
              seq_hold_next = byte_q;
            end else if (byte_index == 8'd4) begin
              system_hold_next = byte_q;
            end else if (byte_index == 8'd5) begin
              module_hold_next = byte_q;
            end else if (byte_index == 8'd6) begin
              msg_hold_next = byte_q;
            end else begin
              pay_we = pay_off < 8'(scfr_pkg::CTRL_STORED_BYTES);
            end
          end else if (byte_index == len_m2) begin
            sum_low_hold_next = byte_q;
            byte_index_next   = byte_index + 8'd1;
          end else begin
            // checksum high byte closes the frame
            phase_next      = scfr_pkg::PH_HUNT_A;
            byte_index_next = '0;
            res_valid       = 1'b1;
            res.frame_seq   = seq_hold;
            res.system_id   = system_hold;
            res.module_id   = module_hold;
            res.message_id  = msg_hold;
            priority if (sum_low_hold != running_sum[7:0] || byte_q != running_sum[15:8]) begin
              res.status = scfr_pkg::ST_CSUM_ERR;
            end else if (msg_hold == scfr_pkg::ID_CONTROL) begin
              if (frame_length < 8'(scfr_pkg::MIN_CONTROL_LEN)) begin
                res.status = scfr_pkg::ST_SHORT;
              end else begin
                res.status       = scfr_pkg::ST_CONTROL;
                res.pitch_tenths = {payload[1], payload[0]};
                res.yaw_tenths   = {payload[3], payload[2]};
                res.zoom_tenths  = {payload[5], payload[4]};
                res.focus_tenths = {payload[7], payload[6]};
                res.home_flag    = payload[8];
                res.picture_flag = payload[9];
                res.camera_mode  = payload[10];
              end
            end else if (msg_hold == scfr_pkg::ID_HEARTBEAT) begin
              res.status = scfr_pkg::ST_HEARTBEAT;
            end else begin
              res.status = scfr_pkg::ST_OTHER;
            end
          end
        end
        default: begin
          phase_next = scfr_pkg::PH_HUNT_A;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### src/scfr_out_buf.sv
// Two-word result buffer between parser and output channel.
`default_nettype none
module scfr_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire scfr_pkg::frame_res_t push_data,
  output logic                      room,
  output logic                      valid,
  input  wire logic                 ready,
  output scfr_pkg::frame_res_t      data
);

  scfr_pkg::frame_res_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign room  = count != 2'd2;
  assign valid = count != 2'd0;
  assign pop   = valid && ready;
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### src/sum_checked_frame_receiver_top.sv
// A frame report's last byte passes through the input register and the parser into the result buffer, which offers it.
// Throughput: one byte per cycle; input stalls only when both result buffer slots are full.
// The parser state update is one short add/compare step between input and result registers.
// Reset (rst, synchronous, active high) returns the parser to sync hunt and empties the
// buffers; stored payload bytes are not cleared.
`default_nettype none
module sum_checked_frame_receiver_top (
  input  wire logic   clk,
  input  wire logic   rst,
  scfr_byte_if.sink   rx,
  scfr_frame_if.source frame
);

  logic                 proc;
  logic [7:0]           byte_q;
  logic                 room;
  logic                 res_valid;
  scfr_pkg::frame_res_t res;
  scfr_pkg::frame_res_t out_data;

  scfr_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .valid   (rx.valid),
    .ready   (rx.ready),
    .rx_byte (rx.rx_byte),
    .room    (room),
    .proc    (proc),
    .byte_q  (byte_q)
  );

  scfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .proc      (proc),
    .byte_q    (byte_q),
    .res_valid (res_valid),
    .res       (res)
  );

  scfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .valid     (frame.valid),
    .ready     (frame.ready),
    .data      (out_data)
  );

  assign frame.status       = out_data.status;
  assign frame.frame_seq    = out_data.frame_seq;
  assign frame.system_id    = out_data.system_id;
  assign frame.module_id    = out_data.module_id;
  assign frame.message_id   = out_data.message_id;
  assign frame.pitch_tenths = out_data.pitch_tenths;
  assign frame.yaw_tenths   = out_data.yaw_tenths;
  assign frame.zoom_tenths  = out_data.zoom_tenths;
  assign frame.focus_tenths = out_data.focus_tenths;
  assign frame.home_flag    = out_data.home_flag;
  assign frame.picture_flag = out_data.picture_flag;
  assign frame.camera_mode  = out_data.camera_mode;

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the sum-checked frame receiver: byte stream in, frame reports out.
`default_nettype none
module tb;
  import scfr_pkg::*;

  localparam int RANDOM_BYTES = 1540;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int SHOW_LIMIT   = 10;

  class frame_report_board;
    phase_t      parse_phase;
    int          idx;
    int          flen;
    logic [15:0] run_sum;
    logic [7:0]  seq_b, sys_b, mod_b, msg_b, low_b;
    logic [7:0]  store [CONTROL_PAYLOAD_BYTES];
    frame_res_t  pending[$];
    int          fail_count;

    function new();
      parse_phase = PH_HUNT_A;
      idx = 0;
      flen = 0;
      run_sum = '0;
      seq_b = '0;
      sys_b = '0;
      mod_b = '0;
      msg_b = '0;
      low_b = '0;
      fail_count = 0;
    endfunction

    function string show(frame_res_t r);
      return $sformatf("st=%0d seq=%h sys=%h mod=%h id=%h p=%h y=%h z=%h f=%h h=%h pic=%h cam=%h",
                       r.status, r.frame_seq, r.system_id, r.module_id, r.message_id,
                       r.pitch_tenths, r.yaw_tenths, r.zoom_tenths, r.focus_tenths,
                       r.home_flag, r.picture_flag, r.camera_mode);
    endfunction

    // advance the parser by one accepted byte, queue the report it causes
    function void note_byte(logic [7:0] b);
      frame_res_t r;
      r = '0;
      case (parse_phase)
        PH_HUNT_A: begin
          if (b == SYNC_A) begin
            run_sum = 16'(SYNC_A);
            parse_phase = PH_HUNT_B;
          end
        end
        PH_HUNT_B: begin
          if (b == SYNC_B) begin
            run_sum = run_sum + 16'(b);
            parse_phase = PH_LENGTH;
          end else if (b == SYNC_A) begin
            run_sum = 16'(SYNC_A);
          end else begin
            parse_phase = PH_HUNT_A;
          end
        end
        PH_LENGTH: begin
          if (int'(b) < MIN_FRAME_LEN) begin
            r.status = ST_SHORT;
            pending.push_back(r);
            parse_phase = PH_HUNT_A;
            idx = 0;
          end else begin
            flen = int'(b);
            run_sum = run_sum + 16'(b);
            idx = 3;
            parse_phase = PH_BODY;
          end
        end
        default: begin
          if (idx < flen - 2) begin
            run_sum = run_sum + 16'(b);
            if (idx == 3) seq_b = b;
            else if (idx == 4) sys_b = b;
            else if (idx == 5) mod_b = b;
            else if (idx == 6) msg_b = b;
            else if (idx - PAYLOAD_START < CONTROL_PAYLOAD_BYTES)
              store[idx - PAYLOAD_START] = b;
            idx++;
          end else if (idx == flen - 2) begin
            low_b = b;
            idx++;
          end else begin
            parse_phase = PH_HUNT_A;
            idx = 0;
            r.frame_seq  = seq_b;
            r.system_id  = sys_b;
            r.module_id  = mod_b;
            r.message_id = msg_b;
            if (low_b != run_sum[7:0] || b != run_sum[15:8]) begin
              r.status = ST_CSUM_ERR;
            end else if (msg_b == ID_CONTROL) begin
              if (flen < MIN_CONTROL_LEN) begin
                r.status = ST_SHORT;
              end else begin
                r.status       = ST_CONTROL;
                r.pitch_tenths = {store[1], store[0]};
                r.yaw_tenths   = {store[3], store[2]};
                r.zoom_tenths  = {store[5], store[4]};
                r.focus_tenths = {store[7], store[6]};
                r.home_flag    = store[8];
                r.picture_flag = store[9];
                r.camera_mode  = store[10];
              end
            end else begin
              r.status = (msg_b == ID_HEARTBEAT) ? ST_HEARTBEAT : ST_OTHER;
            end
            pending.push_back(r);
          end
        end
      endcase
    endfunction

    function void check_report(frame_res_t got);
      frame_res_t want;
      if (pending.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) $display("unexpected report: %s", show(got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("report mismatch");
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  scfr_byte_if  rx_if ();
  scfr_frame_if frame_if ();

  sum_checked_frame_receiver_top uut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .frame (frame_if)
  );

  frame_report_board board = new();

  logic [7:0] fbuf [0:254];
  int bytes_sent    = 0;
  int src_idle_pct  = 21;
  int sink_idle_pct = 21;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int cycles        = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result sink: random stalls plus one long hold-off on request
  initial begin
    frame_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        frame_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        frame_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : report_mon
    frame_res_t got;
    if (!rst && frame_if.valid && frame_if.ready) begin
      got.status       = frame_if.status;
      got.frame_seq    = frame_if.frame_seq;
      got.system_id    = frame_if.system_id;
      got.module_id    = frame_if.module_id;
      got.message_id   = frame_if.message_id;
      got.pitch_tenths = frame_if.pitch_tenths;
      got.yaw_tenths   = frame_if.yaw_tenths;
      got.zoom_tenths  = frame_if.zoom_tenths;
      got.focus_tenths = frame_if.focus_tenths;
      got.home_flag    = frame_if.home_flag;
      got.picture_flag = frame_if.picture_flag;
      got.camera_mode  = frame_if.camera_mode;
      board.check_report(got);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    board.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic fill_frame(input int len, input logic [7:0] id);
    fbuf[0] = SYNC_A;
    fbuf[1] = SYNC_B;
    fbuf[2] = 8'(len);
    for (int i = 3; i < 255; i++) fbuf[i] = 8'($urandom_range(255));
    fbuf[6] = id;
  endtask

  // seal checksum, optionally corrupt it, send the first cut bytes
  task automatic send_frame(input int len, input int cut, input bit bad);
    logic [15:0] csum;
    csum = '0;
    for (int i = 0; i < len - 2; i++) csum = csum + 16'(fbuf[i]);
    fbuf[len - 2] = csum[7:0];
    fbuf[len - 1] = csum[15:8];
    if (bad) fbuf[len - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    for (int i = 0; i < cut; i++) send_byte(fbuf[i]);
  endtask

  initial begin : stim
    int rand_start;
    int sel;
    int len;
    logic [7:0] id;
    bit bad;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_A); send_byte(SYNC_B); send_byte(8'h00);
    send_byte(SYNC_A); send_byte(SYNC_B); send_byte(8'(MIN_FRAME_LEN - 1));
    send_byte(SYNC_A); send_byte(8'h12);
    // doubled sync byte ahead of a minimum heartbeat
    send_byte(SYNC_A);
    fill_frame(MIN_FRAME_LEN, ID_HEARTBEAT);
    send_frame(MIN_FRAME_LEN, MIN_FRAME_LEN, 1'b0);
    fill_frame(MIN_CONTROL_LEN, ID_CONTROL);
    fbuf[3]  = 8'h00; fbuf[4]  = 8'hFF; fbuf[5]  = 8'h80;
    fbuf[7]  = 8'h00; fbuf[8]  = 8'h80;
    fbuf[9]  = 8'hFF; fbuf[10] = 8'h7F;
    fbuf[11] = 8'h00; fbuf[12] = 8'h00;
    fbuf[13] = 8'hFF; fbuf[14] = 8'hFF;
    fbuf[15] = 8'h00; fbuf[16] = 8'hFF; fbuf[17] = 8'h80;
    send_frame(MIN_CONTROL_LEN, MIN_CONTROL_LEN, 1'b0);
    fill_frame(MIN_CONTROL_LEN - 1, ID_CONTROL);
    send_frame(MIN_CONTROL_LEN - 1, MIN_CONTROL_LEN - 1, 1'b0);
    fill_frame(MIN_CONTROL_LEN - 1, ID_CONTROL);
    send_frame(MIN_CONTROL_LEN - 1, MIN_CONTROL_LEN - 1, 1'b1);
    fill_frame(255, 8'h7E);
    send_frame(255, 255, 1'b0);
    fill_frame(12, ID_HEARTBEAT);
    send_frame(12, 12, 1'b1);

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      if (!hold_req && hold_left == 0 && bytes_sent - rand_start >= 600 &&
          bytes_sent - rand_start < 620)
        hold_req = 1'b1;
      if (bytes_sent - rand_start >= 1000 && bytes_sent - rand_start < 1300) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = 21;
        sink_idle_pct = 21;
      end
      sel = $urandom_range(99);
      if (sel < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (sel < 12) begin
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(8'($urandom_range(MIN_FRAME_LEN - 1)));
      end else begin
        case ($urandom_range(3))
          0: id = ID_HEARTBEAT;
          1, 2: id = ID_CONTROL;
          default: id = 8'($urandom_range(255));
        endcase
        if ($urandom_range(99) < 3)
          len = $urandom_range(41, 255);
        else if (id == ID_CONTROL && $urandom_range(99) < 80)
          len = $urandom_range(MIN_CONTROL_LEN, 40);
        else
          len = $urandom_range(MIN_FRAME_LEN, 30);
        bad = ($urandom_range(99) < 15);
        fill_frame(len, id);
        if (sel < 16) send_frame(len, $urandom_range(3, len - 1), bad);
        else send_frame(len, len, bad);
      end
    end

    rx_if.valid <= 1'b0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending.size() != 0)
      $display("reports never seen: %0d", board.pending.size());
    if (board.fail_count == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
